>>> rtl/ptw_pkg.sv
// Shared types and constants of the four-level page table walker.
package ptw_pkg;

    localparam int VA_BITS       = 48;
    localparam int PA_FIELD_BITS = 52;
    localparam int PAGE_SHIFT    = 12;
    localparam int INDEX_BITS    = 9;
    localparam int QUEUE_DEPTH   = 2;
    localparam int APB_ADDR_BITS = 4;
    localparam int REG_IDX_BIT   = 3;

    // Entry bit positions.
    localparam int E_PRESENT  = 0;
    localparam int E_WRITE    = 1;
    localparam int E_USER     = 2;
    localparam int E_ACCESSED = 5;
    localparam int E_DIRTY    = 6;
    localparam int E_PS       = 7;
    localparam int E_NX       = 63;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic {
        REG_DEFAULT_ROOT = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        SZ_4K = 2'd0,
        SZ_2M = 2'd1,
        SZ_1G = 2'd2
    } size_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOP_MISSING  = 3'd1,
        ST_SELF_REF     = 3'd2,
        ST_PDPT_MISSING = 3'd3,
        ST_PD_MISSING   = 3'd4,
        ST_PT_MISSING   = 3'd5,
        ST_ZERO_FRAME   = 3'd6
    } status_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        op_t                  op;
        logic [63:0]          root;
        logic [VA_BITS-1:0]   vaddr;
        logic [63:0]          entry;
        logic                 read_failed;
    } cmd_t;

    typedef struct packed {
        kind_t                    kind;
        logic [PA_FIELD_BITS-1:0] read_addr;
        logic [PA_FIELD_BITS-1:0] phys_addr;
        size_t                    page_size;
        status_t                  status;
        logic                     no_execute;
        logic                     read_only;
        logic                     supervisor_only;
        logic                     accessed;
        logic                     dirty;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
//
// Usage: the input stream carries translate requests (s_tuser 0) and memory
// read responses (s_tuser 1). A translate starts a walk and yields an entry
// read request word on the output stream (m_tuser 0). Each response then
// yields either the next read request or a finished word (m_tuser 1) with the
// physical address, page size, attributes and status. A response that
// arrives with no walk running yields nothing; a translate during a walk
// drops that walk.
// Throughput is one input word per cycle while the receiver keeps taking results.
// An accepted word is written into the two-entry front queue, and the walk
// stage, whose single step per word sets the rate, takes it from the queue
// head and registers its result in the output register that drives m_tvalid.
// When the receiver stalls, the result is held in the output register and the
// queue keeps taking up to two more words before s_tready drops.
// Reset (aresetn low, synchronous) empties the queue, ends any walk and
// clears default_root, set over the APB port at byte address 0.
module four_level_page_table_walker #(
    parameter int PHYS_FRAME_BITS = 40
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // root[63:0], virt_addr[111:64], entry_data[175:112], read_failed[176]
    input  logic [183:0]                      s_tdata,
    // op[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_addr[51:0], phys_addr[103:52], page_size[105:104], status[108:106],
    // no_execute[109], read_only[110], supervisor_only[111], accessed[112],
    // dirty[113]
    output logic [119:0]                      m_tdata,
    // kind[0]
    output logic                              m_tuser
);

    ptw_pkg::queue_status_t q_status;
    ptw_pkg::cmd_t          push_cmd;
    ptw_pkg::cmd_t          head_cmd;
    ptw_pkg::res_t          res;
    logic                   push;
    logic                   pop;

    assign pready = 1'b1;

    ptw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ptw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    ptw_back #(
        .PHYS_FRAME_BITS (PHYS_FRAME_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!q_status.empty),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .m_tready  (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {6'b000000, res.dirty, res.accessed, res.supervisor_only,
                      res.read_only, res.no_execute, res.status, res.page_size,
                      res.phys_addr, res.read_addr};

    // The queue only refuses input while it holds words.
    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !q_status.empty)
        else $error("input refused while queue empty");

    // A failed walk carries no translation.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ptw_pkg::KIND_DONE && res.status != ptw_pkg::ST_OK)
        |-> (res.phys_addr == '0 && res.page_size == ptw_pkg::SZ_4K &&
             res.read_addr == '0))
        else $error("failed walk result carries address data");

    // A read request word has ok status and no translation fields.
    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ptw_pkg::KIND_READ)
        |-> (res.status == ptw_pkg::ST_OK && res.phys_addr == '0 &&
             res.accessed == 1'b0 && res.dirty == 1'b0))
        else $error("read request word carries result fields");

    // Nothing leaves the back without a word taken from the queue.
    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop))
        else $error("output word without queue pop");

endmodule

>>> rtl/ptw_front.sv
// Front end: configuration register, input acceptance and root selection.
module ptw_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [183:0]                      s_tdata,
    input  logic                              s_tuser,
    input  ptw_pkg::queue_status_t            q_status,
    output logic                              push,
    output ptw_pkg::cmd_t                     push_cmd
);

    logic [63:0] default_root_reg;
    logic [63:0] default_root_next;
    logic [63:0] in_root;

    always_comb begin
        default_root_next = default_root_reg;
        if (psel && penable && pwrite &&
            paddr[ptw_pkg::REG_IDX_BIT] == ptw_pkg::REG_DEFAULT_ROOT) begin
            default_root_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_root_reg <= '0;
        end else begin
            default_root_reg <= default_root_next;
        end
    end

    assign prdata = (paddr[ptw_pkg::REG_IDX_BIT] == ptw_pkg::REG_DEFAULT_ROOT) ?
                    default_root_reg : '0;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    // A zero root in a translate word falls back to the default root register.
    assign in_root = (s_tdata[63:0] != 64'd0) ? s_tdata[63:0] : default_root_reg;

    always_comb begin
        push_cmd.op          = ptw_pkg::op_t'(s_tuser);
        push_cmd.root        = in_root;
        push_cmd.vaddr       = s_tdata[111:64];
        push_cmd.entry       = s_tdata[175:112];
        push_cmd.read_failed = s_tdata[176];
    end

endmodule

>>> rtl/ptw_queue.sv
// Short first-in first-out queue between the front and the back.
module ptw_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ptw_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output ptw_pkg::cmd_t          head_cmd,
    output ptw_pkg::queue_status_t q_status
);

    localparam int DEPTH   = ptw_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    ptw_pkg::cmd_t       mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd       = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == COUNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

>>> rtl/ptw_back.sv
// Back end: walk state machine, one queued word per step, registered result.
module ptw_back #(
    parameter int PHYS_FRAME_BITS = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  ptw_pkg::cmd_t head_cmd,
    output logic          pop,
    input  logic          m_tready,
    output logic          res_valid,
    output ptw_pkg::res_t res
);

    localparam int PA_BITS = PHYS_FRAME_BITS + ptw_pkg::PAGE_SHIFT;
    localparam int IB      = ptw_pkg::INDEX_BITS;
    localparam int PS      = ptw_pkg::PAGE_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PML4,
        S_PDPT,
        S_PD,
        S_PT
    } walk_state_t;

    walk_state_t                   state_reg, state_next;
    logic [PHYS_FRAME_BITS-1:0]    root_frame_reg, root_frame_next;
    logic [ptw_pkg::VA_BITS-1:0]   vaddr_reg, vaddr_next;
    logic [2:0]                    attr_reg, attr_next;
    logic                          out_valid_reg;
    ptw_pkg::res_t                 out_res_reg;

    logic                          take;
    logic                          has_res;
    ptw_pkg::res_t                 res_next;
    logic [63:0]                   e;
    logic [PHYS_FRAME_BITS-1:0]    ef;
    logic [PHYS_FRAME_BITS-1:0]    in_frame;
    logic                          ok;
    logic [2:0]                    attr_g;
    ptw_pkg::size_t                leaf_size;
    logic [PA_BITS-1:0]            off_mask;
    logic [PA_BITS-1:0]            base;
    ptw_pkg::res_t                 leaf_res;
    ptw_pkg::res_t                 fail_res;

    assign take     = q_valid && (!out_valid_reg || m_tready);
    assign pop      = take;
    assign e        = head_cmd.entry;
    assign ef       = e[PS +: PHYS_FRAME_BITS];
    assign in_frame = head_cmd.root[PS +: PHYS_FRAME_BITS];
    assign ok       = !head_cmd.read_failed && e[ptw_pkg::E_PRESENT];
    assign attr_g   = attr_reg | {~e[ptw_pkg::E_USER], ~e[ptw_pkg::E_WRITE], e[ptw_pkg::E_NX]};

    // Leaf completion: size depends on the level where the walk stops.
    always_comb begin
        unique case (state_reg)
            S_PDPT:  leaf_size = ptw_pkg::SZ_1G;
            S_PD:    leaf_size = ptw_pkg::SZ_2M;
            default: leaf_size = ptw_pkg::SZ_4K;
        endcase
        unique case (leaf_size)
            ptw_pkg::SZ_1G: off_mask = ~({PA_BITS{1'b1}} << (PS + 2 * IB));
            ptw_pkg::SZ_2M: off_mask = ~({PA_BITS{1'b1}} << (PS + IB));
            default:        off_mask = ~({PA_BITS{1'b1}} << PS);
        endcase
        base = e[PA_BITS-1:0] & ~off_mask;

        leaf_res      = '0;
        leaf_res.kind = ptw_pkg::KIND_DONE;
        if (base == '0) begin
            leaf_res.status = ptw_pkg::ST_ZERO_FRAME;
        end else begin
            leaf_res.status          = ptw_pkg::ST_OK;
            leaf_res.phys_addr       = ptw_pkg::PA_FIELD_BITS'(
                base | (PA_BITS'(vaddr_reg) & off_mask));
            leaf_res.page_size       = leaf_size;
            leaf_res.no_execute      = attr_g[0];
            leaf_res.read_only       = attr_g[1];
            leaf_res.supervisor_only = attr_g[2];
            leaf_res.accessed        = e[ptw_pkg::E_ACCESSED];
            leaf_res.dirty           = e[ptw_pkg::E_DIRTY];
        end
    end

    always_comb begin
        state_next      = state_reg;
        root_frame_next = root_frame_reg;
        vaddr_next      = vaddr_reg;
        attr_next       = attr_reg;
        has_res         = 1'b0;
        res_next        = '0;
        fail_res        = '0;
        fail_res.kind   = ptw_pkg::KIND_DONE;

        if (head_cmd.op == ptw_pkg::OP_TRANSLATE) begin
            // A new request drops whatever walk is running.
            root_frame_next    = in_frame;
            vaddr_next         = head_cmd.vaddr;
            attr_next          = '0;
            state_next         = S_PML4;
            has_res            = 1'b1;
            res_next.kind      = ptw_pkg::KIND_READ;
            res_next.read_addr = ptw_pkg::PA_FIELD_BITS'(
                {in_frame, head_cmd.vaddr[PS + 3 * IB +: IB], 3'b000});
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    // A response with no walk running is dropped.
                end
                S_PML4: begin
                    has_res = 1'b1;
                    if (!ok) begin
                        fail_res.status = ptw_pkg::ST_TOP_MISSING;
                        res_next        = fail_res;
                        state_next      = S_IDLE;
                    end else if (ef == root_frame_reg) begin
                        fail_res.status = ptw_pkg::ST_SELF_REF;
                        res_next        = fail_res;
                        state_next      = S_IDLE;
                    end else begin
                        res_next.kind      = ptw_pkg::KIND_READ;
                        res_next.read_addr = ptw_pkg::PA_FIELD_BITS'(
                            {ef, vaddr_reg[PS + 2 * IB +: IB], 3'b000});
                        state_next         = S_PDPT;
                    end
                end
                S_PDPT: begin
                    has_res = 1'b1;
                    if (!ok) begin
                        fail_res.status = ptw_pkg::ST_PDPT_MISSING;
                        res_next        = fail_res;
                        state_next      = S_IDLE;
                    end else begin
                        attr_next = attr_g;
                        if (e[ptw_pkg::E_PS]) begin
                            res_next   = leaf_res;
                            state_next = S_IDLE;
                        end else begin
                            res_next.kind      = ptw_pkg::KIND_READ;
                            res_next.read_addr = ptw_pkg::PA_FIELD_BITS'(
                                {ef, vaddr_reg[PS + IB +: IB], 3'b000});
                            state_next         = S_PD;
                        end
                    end
                end
                S_PD: begin
                    has_res = 1'b1;
                    if (!ok) begin
                        fail_res.status = ptw_pkg::ST_PD_MISSING;
                        res_next        = fail_res;
                        state_next      = S_IDLE;
                    end else begin
                        attr_next = attr_g;
                        if (e[ptw_pkg::E_PS]) begin
                            res_next   = leaf_res;
                            state_next = S_IDLE;
                        end else begin
                            res_next.kind      = ptw_pkg::KIND_READ;
                            res_next.read_addr = ptw_pkg::PA_FIELD_BITS'(
                                {ef, vaddr_reg[PS +: IB], 3'b000});
                            state_next         = S_PT;
                        end
                    end
                end
                S_PT: begin
                    has_res    = 1'b1;
                    state_next = S_IDLE;
                    if (!ok) begin
                        fail_res.status = ptw_pkg::ST_PT_MISSING;
                        res_next        = fail_res;
                    end else begin
                        // The size bit means nothing in a PT entry.
                        attr_next = attr_g;
                        res_next  = leaf_res;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            root_frame_reg <= '0;
            vaddr_reg      <= '0;
            attr_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                state_reg      <= state_next;
                root_frame_reg <= root_frame_next;
                vaddr_reg      <= vaddr_next;
                attr_reg       <= attr_next;
                out_valid_reg  <= has_res;
                if (has_res) begin
                    out_res_reg <= res_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule
